FILE: rtl/fixed_layout_message_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed layout message parser
// Checks are compiled for simulation only and vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIXED_LAYOUT_MESSAGE_PARSER_DEFINES_SVH
`define FIXED_LAYOUT_MESSAGE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define FMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fmp assertion failed");
// same check with a message of its own
`define FMP_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define FMP_ASSERT(lbl, prop)
`define FMP_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

FILE: rtl/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg
// Types and constants shared by the message parser modules.
// ----------------------------------------------------------------------------
package fmp_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // parse phases
  localparam logic [3:0] PH_MAGIC   = 4'd0;
  localparam logic [3:0] PH_VERSION = 4'd1;
  localparam logic [3:0] PH_SRC     = 4'd2;
  localparam logic [3:0] PH_DST     = 4'd3;
  localparam logic [3:0] PH_NONCE   = 4'd4;
  localparam logic [3:0] PH_EXPIRY  = 4'd5;
  localparam logic [3:0] PH_AMOUNT  = 4'd6;
  localparam logic [3:0] PH_TOKEN   = 4'd7;
  localparam logic [3:0] PH_RECIP   = 4'd8;
  localparam logic [3:0] PH_MEMOLEN = 4'd9;
  localparam logic [3:0] PH_MEMO    = 4'd10;
  localparam logic [3:0] PH_DONE    = 4'd11;

  // field tags
  localparam logic [3:0] TAG_NONE    = 4'd0;
  localparam logic [3:0] TAG_SRC     = 4'd1;
  localparam logic [3:0] TAG_TOKEN   = 4'd6;
  localparam logic [3:0] TAG_RECIP   = 4'd7;
  localparam logic [3:0] TAG_MEMOLEN = 4'd8;
  localparam logic [3:0] TAG_MEMO    = 4'd9;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
  localparam logic [2:0] ERR_MAGIC     = 3'd2;
  localparam logic [2:0] ERR_VERSION   = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;
  localparam logic [2:0] ERR_MEMO_LONG = 3'd5;
  localparam logic [2:0] ERR_TRAILING  = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MEMO    = 1'd1;

  localparam logic [15:0] MAX_MESSAGE_RST = 16'd4096;
  localparam logic [15:0] MAX_MEMO_RST    = 16'd256;
  localparam logic [16:0] TOTAL_SAT       = 17'h1FFFF;

  localparam logic [7:0] MAGIC_B0 = 8'h42;  // 'B'
  localparam logic [7:0] MAGIC_B1 = 8'h52;  // 'R'
  localparam logic [7:0] MAGIC_B2 = 8'h47;  // 'G'
  localparam logic [7:0] MAGIC_B3 = 8'h32;  // '2'
  localparam logic [31:0] VERSION_ONE = 32'd1;

  typedef struct packed {
    logic [3:0]  field_tag;
    logic [63:0] field_value;
    logic [15:0] array_index;
    logic        message_done;
    logic        message_ok;
    logic [2:0]  error_code;
  } fmp_result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0: b = MAGIC_B0;
      2'd1: b = MAGIC_B1;
      2'd2: b = MAGIC_B2;
      default: b = MAGIC_B3;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/fmp_if.sv
// ----------------------------------------------------------------------------
// fmp channel interfaces
// Valid/ready channels for message bytes, parse results and register writes.
// ----------------------------------------------------------------------------
interface fmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface fmp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_tag;
  logic [63:0] field_value;
  logic [15:0] array_index;
  logic        message_done;
  logic        message_ok;
  logic [2:0]  error_code;

  modport source (output valid, output field_tag, output field_value,
                  output array_index, output message_done, output message_ok,
                  output error_code, input ready);
  modport sink (input valid, input field_tag, input field_value,
                input array_index, input message_done, input message_ok,
                input error_code, output ready);
endinterface

interface fmp_cfg_if;
  import fmp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/fmp_parse_core.sv
// ----------------------------------------------------------------------------
// fmp_parse_core
// Message parse state and the per-word next-state and result logic.
// ----------------------------------------------------------------------------
`include "fixed_layout_message_parser_defines.svh"

module fmp_parse_core #(
  parameter int unsigned TOKEN_BYTES     = 32,
  parameter int unsigned RECIPIENT_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  input  logic [15:0]         max_message_bytes_i,
  input  logic [15:0]         memo_limit_i,
  output fmp_pkg::fmp_result_t result_o
);
  import fmp_pkg::*;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [16:0] total_q, total_d;
  logic [63:0] acc_q, acc_d;
  logic [15:0] memo_size_q, memo_size_d;
  logic [2:0]  err_q, err_d;

  logic [16:0] total_inc;
  logic [16:0] cnt_inc;
  logic [63:0] acc_or;
  logic [31:0] word;
  fmp_result_t res;
  logic        msg_end;
  logic        total_sat;

  assign total_inc = (total_q == TOTAL_SAT) ? total_q : total_q + 17'd1;
  assign cnt_inc   = {1'b0, cnt_q} + 17'd1;
  assign acc_or    = acc_q | ({56'd0, data_byte_i} << {cnt_q[2:0], 3'b000});
  assign word      = acc_or[31:0];

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    total_d     = total_inc;
    acc_d       = acc_q;
    memo_size_d = memo_size_q;
    err_d       = err_q;
    res         = '0;

    if (total_inc > {1'b0, max_message_bytes_i}) begin
      err_d = ERR_TOO_LONG;
    end else if (err_q == ERR_NONE) begin
      case (phase_q)
        PH_MAGIC: begin
          if (data_byte_i != magic_byte(cnt_q[1:0])) begin
            err_d = ERR_MAGIC;
          end else if (cnt_inc >= 17'd4) begin
            phase_d = PH_VERSION;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc[15:0];
          end
        end
        PH_VERSION, PH_MEMOLEN: begin
          if (cnt_inc >= 17'd4) begin
            cnt_d = '0;
            acc_d = '0;
            if (phase_q == PH_VERSION) begin
              if (word != VERSION_ONE) begin
                err_d = ERR_VERSION;
              end else begin
                phase_d = PH_SRC;
              end
            end else begin
              memo_size_d = word[15:0];
              if (word > {16'd0, memo_limit_i}) begin
                err_d = ERR_MEMO_LONG;
              end else begin
                res.field_tag   = TAG_MEMOLEN;
                res.field_value = {32'd0, word};
                phase_d = (word == 32'd0) ? PH_DONE : PH_MEMO;
              end
            end
          end else begin
            cnt_d = cnt_inc[15:0];
            acc_d = acc_or;
          end
        end
        PH_SRC, PH_DST, PH_NONCE, PH_EXPIRY, PH_AMOUNT: begin
          if (cnt_inc >= 17'd8) begin
            res.field_tag   = phase_q - (PH_SRC - TAG_SRC);
            res.field_value = acc_or;
            phase_d = phase_q + 4'd1;
            cnt_d   = '0;
            acc_d   = '0;
          end else begin
            cnt_d = cnt_inc[15:0];
            acc_d = acc_or;
          end
        end
        PH_TOKEN, PH_RECIP: begin
          res.field_tag   = (phase_q == PH_TOKEN) ? TAG_TOKEN : TAG_RECIP;
          res.field_value = {56'd0, data_byte_i};
          res.array_index = cnt_q;
          if (cnt_inc >= ((phase_q == PH_TOKEN) ? 17'(TOKEN_BYTES)
                                                : 17'(RECIPIENT_BYTES))) begin
            phase_d = phase_q + 4'd1;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc[15:0];
          end
        end
        PH_MEMO: begin
          res.field_tag   = TAG_MEMO;
          res.field_value = {56'd0, data_byte_i};
          res.array_index = cnt_q;
          if (cnt_inc >= {1'b0, memo_size_q}) begin
            phase_d = PH_DONE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc[15:0];
          end
        end
        default: begin
          err_d = ERR_TRAILING;
        end
      endcase
    end

    if (final_byte_i) begin
      if (err_d == ERR_NONE && phase_d != PH_DONE) begin
        err_d = ERR_TRUNC;
      end
      res.message_done = 1'b1;
      res.message_ok   = (err_d == ERR_NONE);
    end
    res.error_code = err_d;

    // message boundary: back to the start state
    if (final_byte_i) begin
      phase_d     = PH_MAGIC;
      cnt_d       = '0;
      total_d     = '0;
      acc_d       = '0;
      memo_size_d = '0;
      err_d       = ERR_NONE;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      cnt_q       <= '0;
      total_q     <= '0;
      acc_q       <= '0;
      memo_size_q <= '0;
      err_q       <= ERR_NONE;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      acc_q       <= acc_d;
      memo_size_q <= memo_size_d;
      err_q       <= err_d;
    end
  end

  assign msg_end   = fire_i && final_byte_i;
  assign total_sat = (total_q == TOTAL_SAT);

  `FMP_ASSERT(a_final_clears, msg_end |=> (phase_q == PH_MAGIC && err_q == ERR_NONE))
  `FMP_ASSERT_MSG(a_err_sticky, (err_q != ERR_NONE && !msg_end) |=> (err_q != ERR_NONE), "err lost")
  `FMP_ASSERT(a_magic_cnt, (phase_q == PH_MAGIC) |-> (cnt_q < 16'd4))
  `FMP_ASSERT_MSG(a_total_sat, (total_sat && !msg_end) |=> total_sat, "count left saturation")

endmodule

FILE: rtl/fmp_out_reg.sv
// ----------------------------------------------------------------------------
// fmp_out_reg
// Result register with valid/ready handshake toward the receiver.
// ----------------------------------------------------------------------------
module fmp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  fmp_pkg::fmp_result_t result_i,
  output logic                ready_o,
  fmp_out_if.source           out_o
);
  import fmp_pkg::*;

  logic        valid_q;
  fmp_result_t data_q;

  // a new word may enter while the held one is taken in the same cycle
  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.field_tag    = data_q.field_tag;
  assign out_o.field_value  = data_q.field_value;
  assign out_o.array_index  = data_q.array_index;
  assign out_o.message_done = data_q.message_done;
  assign out_o.message_ok   = data_q.message_ok;
  assign out_o.error_code   = data_q.error_code;

endmodule

FILE: rtl/fixed_layout_message_parser.sv
// ----------------------------------------------------------------------------
// fixed_layout_message_parser
// Byte-serial parser for the fixed layout transfer message.
// ----------------------------------------------------------------------------
// Channels: in_i takes one message byte per word with final_byte on the last
// byte; out_o gives exactly one result word per input word, in order; cfg_i
// writes the message length limit (index 0) and the memo length limit
// (index 1) and is always ready. Write registers only while no word is in flight.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the receiver keeps out_o.ready high, set
// by the single result register that follows the parse logic; the state update
// per byte is a counter step and a byte insert into the 64-bit accumulator.
// Reset: parse state goes to the start of a message, limits go to 4096 and
// 256 bytes, the result register empties.
// Stall: while the receiver holds out_o.ready low with a result waiting,
// in_i.ready drops and the input is held off; when the result is taken a
// new byte is accepted in that same cycle.
// ----------------------------------------------------------------------------
module fixed_layout_message_parser #(
  parameter int unsigned TOKEN_BYTES     = 32,
  parameter int unsigned RECIPIENT_BYTES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fmp_in_if.sink    in_i,
  fmp_out_if.source out_o,
  fmp_cfg_if.sink   cfg_i
);
  import fmp_pkg::*;

  logic [15:0] max_message_q;
  logic [15:0] max_memo_q;
  logic        stage_ready;
  logic        fire;
  fmp_result_t result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_message_q <= MAX_MESSAGE_RST;
      max_memo_q    <= MAX_MEMO_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MAX_MESSAGE: max_message_q <= cfg_i.data;
        REG_MAX_MEMO:    max_memo_q    <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready = stage_ready;
  assign fire       = in_i.valid && stage_ready;

  fmp_parse_core #(
    .TOKEN_BYTES     (TOKEN_BYTES),
    .RECIPIENT_BYTES (RECIPIENT_BYTES)
  ) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .fire_i              (fire),
    .data_byte_i         (in_i.data_byte),
    .final_byte_i        (in_i.final_byte),
    .max_message_bytes_i (max_message_q),
    .memo_limit_i        (max_memo_q),
    .result_o            (result)
  );

  fmp_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (result),
    .ready_o  (stage_ready),
    .out_o    (out_o)
  );

endmodule
